// ===== src/bcrc_pkg.sv =====
// Shared types and constants of the bus command retry controller.
package bcrc_pkg;

    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_SEND_REPLY = 3'd1;
    localparam logic [2:0] ACT_SEND_ONLY  = 3'd2;
    localparam logic [2:0] ACT_FRAME      = 3'd3;
    localparam logic [2:0] ACT_CANCEL     = 3'd4;

    localparam logic [1:0] FRAME_GOOD = 2'd0;
    localparam logic [1:0] FRAME_CRC  = 2'd1;

    localparam logic [2:0] ST_SUCCESS = 3'd0;
    localparam logic [2:0] ST_TIMEOUT = 3'd1;
    localparam logic [2:0] ST_CRC     = 3'd2;
    localparam logic [2:0] ST_NAK     = 3'd3;
    localparam logic [2:0] ST_FAILED  = 3'd4;

    localparam logic [2:0] CFG_RETRY_LIMIT = 3'd0;
    localparam logic [2:0] CFG_RETRY_EN    = 3'd1;
    localparam logic [2:0] CFG_IDLE_WAIT   = 3'd2;
    localparam logic [2:0] CFG_REPLY_WAIT  = 3'd3;
    localparam logic [2:0] CFG_RETRY_PAUSE = 3'd4;
    localparam logic [2:0] CFG_NAK_CODE    = 3'd5;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef struct packed {
        logic [2:0] action;
        logic       bus_idle;
        logic       send_ok;
        logic [1:0] frame_class;
        logic       frame_is_echo;
        logic       frame_has_data;
        logic [7:0] frame_first_byte;
    } in_beat_t;

    typedef struct packed {
        logic [1:0] mode_now;
        logic       send_refused;
        logic       transmit_now;
        logic       command_done;
        logic [2:0] done_status;
        logic       unsolicited;
        logic [7:0] retries_used;
    } out_beat_t;

    typedef struct packed {
        logic [7:0]  retry_limit;
        logic        retry_en;
        logic [15:0] idle_wait_limit;
        logic [15:0] reply_wait_limit;
        logic [15:0] retry_pause;
        logic [7:0]  nak_code;
    } cfg_t;

    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_TICK,
        CMD_SEND,
        CMD_FRAME,
        CMD_CANCEL
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t kind;
        logic      bus_idle;
        logic      send_ok;
        logic      want_reply;
        logic      frame_good;
        logic      frame_crc;
        logic      frame_echo;
        logic      frame_nak;
    } cmd_t;

endpackage

// ===== src/bus_command_retry_controller.sv =====
// Top level: configuration registers, front end, command queue and protocol engine.
// Each accepted input beat is stored in the queue, then the engine takes it and registers its result beat.
// Throughput: one beat per cycle while the result side is ready, set by the state update of the engine.
// The queue absorbs short stalls of the result side without blocking the input side.
// Reset clears the protocol state, empties the queue and restores register defaults.
module bus_command_retry_controller #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  bcrc_pkg::in_beat_t                 s_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output bcrc_pkg::out_beat_t                m_data,
    input  logic                               cfg_we,
    input  logic [bcrc_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [bcrc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    bcrc_pkg::cfg_t cfg_reg;
    bcrc_pkg::cmd_t front_cmd;
    bcrc_pkg::cmd_t queue_cmd;
    logic queue_full;
    logic queue_not_empty;
    logic queue_pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.retry_limit <= 8'd3;
            cfg_reg.retry_en <= 1'b1;
            cfg_reg.idle_wait_limit <= 16'd10;
            cfg_reg.reply_wait_limit <= 16'd100;
            cfg_reg.retry_pause <= 16'd10;
            cfg_reg.nak_code <= 8'd21;
        end else if (cfg_we) begin
            unique case (cfg_index)
                bcrc_pkg::CFG_RETRY_LIMIT: cfg_reg.retry_limit <= cfg_wdata[7:0];
                bcrc_pkg::CFG_RETRY_EN:    cfg_reg.retry_en <= cfg_wdata[0];
                bcrc_pkg::CFG_IDLE_WAIT:   cfg_reg.idle_wait_limit <= cfg_wdata;
                bcrc_pkg::CFG_REPLY_WAIT:  cfg_reg.reply_wait_limit <= cfg_wdata;
                bcrc_pkg::CFG_RETRY_PAUSE: cfg_reg.retry_pause <= cfg_wdata;
                bcrc_pkg::CFG_NAK_CODE:    cfg_reg.nak_code <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = !queue_full;

    bcrc_front u_front (
        .in_beat  (s_data),
        .nak_code (cfg_reg.nak_code),
        .cmd      (front_cmd)
    );

    bcrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (s_valid),
        .push_data (front_cmd),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .pop_data  (queue_cmd)
    );

    bcrc_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .cmd_valid (queue_not_empty),
        .cmd       (queue_cmd),
        .cmd_pop   (queue_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// ===== src/bcrc_front.sv =====
// Front end: decodes an input beat into a classified command for the queue.
module bcrc_front (
    input  bcrc_pkg::in_beat_t in_beat,
    input  logic [7:0]         nak_code,
    output bcrc_pkg::cmd_t     cmd
);

    always_comb begin
        cmd = '0;
        cmd.kind = bcrc_pkg::CMD_NOP;
        cmd.bus_idle = in_beat.bus_idle;
        cmd.send_ok = in_beat.send_ok;
        cmd.want_reply = (in_beat.action == bcrc_pkg::ACT_SEND_REPLY);
        cmd.frame_good = (in_beat.frame_class == bcrc_pkg::FRAME_GOOD);
        cmd.frame_crc = (in_beat.frame_class == bcrc_pkg::FRAME_CRC);
        cmd.frame_echo = in_beat.frame_is_echo;
        cmd.frame_nak = in_beat.frame_has_data && (in_beat.frame_first_byte == nak_code);
        unique case (in_beat.action)
            bcrc_pkg::ACT_TICK: begin
                cmd.kind = bcrc_pkg::CMD_TICK;
            end
            bcrc_pkg::ACT_SEND_REPLY, bcrc_pkg::ACT_SEND_ONLY: begin
                cmd.kind = bcrc_pkg::CMD_SEND;
            end
            bcrc_pkg::ACT_FRAME: begin
                cmd.kind = bcrc_pkg::CMD_FRAME;
            end
            bcrc_pkg::ACT_CANCEL: begin
                cmd.kind = bcrc_pkg::CMD_CANCEL;
            end
            default: begin
                cmd.kind = bcrc_pkg::CMD_NOP;
            end
        endcase
    end

endmodule

// ===== src/bcrc_queue.sv =====
// Short command queue between the front end and the protocol engine.
module bcrc_queue #(
    parameter int DEPTH = 2
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  bcrc_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output bcrc_pkg::cmd_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bcrc_pkg::cmd_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_push, do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push = push && !full;
    assign do_pop = pop && not_empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/bcrc_engine.sv =====
// Protocol engine: pending slot, retry state machine and the result register.
module bcrc_engine (
    input  logic                aclk,
    input  logic                aresetn,
    input  bcrc_pkg::cfg_t      cfg,
    input  logic                cmd_valid,
    input  bcrc_pkg::cmd_t      cmd,
    output logic                cmd_pop,
    output logic                m_valid,
    input  logic                m_ready,
    output bcrc_pkg::out_beat_t m_data
);

    typedef enum logic [1:0] {
        MODE_IDLE       = 2'd0,
        MODE_WAIT_BUS   = 2'd1,
        MODE_WAIT_REPLY = 2'd2,
        MODE_RETRY      = 2'd3
    } mode_t;

    mode_t mode_reg, mode_next;
    logic [15:0] ticks_reg, ticks_next;
    logic [7:0] tally_reg, tally_next;
    logic pending_reg, pending_next;
    logic wants_reg, wants_next;
    logic echo_reg, echo_next;
    logic m_valid_reg, m_valid_next;
    bcrc_pkg::out_beat_t m_data_reg, m_data_next;

    logic [15:0] ticks_inc;
    logic [7:0] tally_inc;
    logic fail_req, retry_req, fin_req, enter_req;
    logic [2:0] fail_st, fin_st;
    mode_t enter_mode;
    logic done, tx, refused, unsol;

    assign cmd_pop = cmd_valid && (!m_valid_reg || m_ready);
    assign m_valid = m_valid_reg;
    assign m_data = m_data_reg;
    assign ticks_inc = (ticks_reg == 16'hFFFF) ? ticks_reg : ticks_reg + 16'd1;
    assign tally_inc = (tally_reg == 8'hFF) ? tally_reg : tally_reg + 8'd1;

    always_comb begin
        mode_next = mode_reg;
        ticks_next = ticks_reg;
        tally_next = tally_reg;
        pending_next = pending_reg;
        wants_next = wants_reg;
        echo_next = echo_reg;
        fail_req = 1'b0;
        fail_st = bcrc_pkg::ST_SUCCESS;
        retry_req = 1'b0;
        fin_req = 1'b0;
        fin_st = bcrc_pkg::ST_SUCCESS;
        enter_req = 1'b0;
        enter_mode = MODE_IDLE;
        done = 1'b0;
        tx = 1'b0;
        refused = 1'b0;
        unsol = 1'b0;

        unique case (cmd.kind)
            bcrc_pkg::CMD_TICK: begin
                ticks_next = ticks_inc;
                unique case (mode_reg)
                    MODE_WAIT_BUS: begin
                        if (cmd.bus_idle) begin
                            if (pending_reg && cmd.send_ok) begin
                                tx = 1'b1;
                                echo_next = 1'b1;
                                if (wants_reg) begin
                                    enter_req = 1'b1;
                                    enter_mode = MODE_WAIT_REPLY;
                                end else begin
                                    fin_req = 1'b1;
                                    fin_st = bcrc_pkg::ST_SUCCESS;
                                end
                            end else begin
                                echo_next = 1'b0;
                                fin_req = 1'b1;
                                fin_st = bcrc_pkg::ST_FAILED;
                            end
                        end else if (ticks_inc >= cfg.idle_wait_limit) begin
                            fail_req = 1'b1;
                            fail_st = bcrc_pkg::ST_TIMEOUT;
                        end
                    end
                    MODE_WAIT_REPLY: begin
                        if (ticks_inc >= cfg.reply_wait_limit) begin
                            fail_req = 1'b1;
                            fail_st = bcrc_pkg::ST_TIMEOUT;
                        end
                    end
                    MODE_RETRY: begin
                        if (ticks_inc >= cfg.retry_pause) begin
                            enter_req = 1'b1;
                            enter_mode = MODE_WAIT_BUS;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            bcrc_pkg::CMD_SEND: begin
                if (pending_reg) begin
                    refused = 1'b1;
                end else begin
                    pending_next = 1'b1;
                    wants_next = cmd.want_reply;
                    tally_next = '0;
                    enter_req = 1'b1;
                    enter_mode = MODE_WAIT_BUS;
                end
            end
            bcrc_pkg::CMD_FRAME: begin
                if (echo_reg) begin
                    echo_next = 1'b0;
                end
                if (!(echo_reg && cmd.frame_echo)) begin
                    if (cmd.frame_crc) begin
                        if (mode_reg == MODE_WAIT_REPLY) begin
                            fail_req = 1'b1;
                            fail_st = bcrc_pkg::ST_CRC;
                        end
                    end else if (cmd.frame_good) begin
                        if (pending_reg && wants_reg && mode_reg == MODE_WAIT_REPLY) begin
                            if (cmd.frame_nak) begin
                                fail_req = 1'b1;
                                fail_st = bcrc_pkg::ST_NAK;
                            end else begin
                                fin_req = 1'b1;
                                fin_st = bcrc_pkg::ST_SUCCESS;
                            end
                        end else begin
                            unsol = 1'b1;
                        end
                    end
                end
            end
            bcrc_pkg::CMD_CANCEL: begin
                fin_req = 1'b1;
                fin_st = bcrc_pkg::ST_FAILED;
            end
            default: begin
            end
        endcase

        if (fail_req) begin
            if (cfg.retry_en) begin
                retry_req = 1'b1;
            end else begin
                fin_req = 1'b1;
                fin_st = fail_st;
            end
        end
        if (retry_req && pending_reg) begin
            tally_next = tally_inc;
            if (tally_inc >= cfg.retry_limit) begin
                fin_req = 1'b1;
                fin_st = bcrc_pkg::ST_TIMEOUT;
            end else begin
                enter_req = 1'b1;
                enter_mode = MODE_RETRY;
            end
        end
        if (fin_req && pending_reg) begin
            done = 1'b1;
            pending_next = 1'b0;
            mode_next = MODE_IDLE;
            ticks_next = '0;
        end else if (enter_req) begin
            mode_next = enter_mode;
            ticks_next = '0;
        end

        m_data_next.mode_now = mode_next;
        m_data_next.send_refused = refused;
        m_data_next.transmit_now = tx;
        m_data_next.command_done = done;
        m_data_next.done_status = done ? fin_st : bcrc_pkg::ST_SUCCESS;
        m_data_next.unsolicited = unsol;
        m_data_next.retries_used = tally_next;

        m_valid_next = m_valid_reg;
        if (cmd_pop) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_IDLE;
            ticks_reg <= '0;
            tally_reg <= '0;
            pending_reg <= 1'b0;
            wants_reg <= 1'b0;
            echo_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (cmd_pop) begin
                mode_reg <= mode_next;
                ticks_reg <= ticks_next;
                tally_reg <= tally_next;
                pending_reg <= pending_next;
                wants_reg <= wants_next;
                echo_reg <= echo_next;
                m_data_reg <= m_data_next;
            end
        end
    end

endmodule

// ===== test/bus_command_retry_controller_tb.sv =====
// Self-checking testbench of the bus command retry controller: directed table, then random phases.
`timescale 1ns / 1ps

module bus_command_retry_controller_tb;

    typedef enum logic [1:0] {
        LINK_IDLE,
        LINK_WAIT_BUS,
        LINK_WAIT_REPLY,
        LINK_BACKOFF
    } link_mode_t;

    typedef struct {
        bcrc_pkg::in_beat_t  beat;
        bit                  typed;
        bcrc_pkg::out_beat_t want;
    } plan_row_t;

    localparam logic [2:0] ACT_RSVD5   = 3'd5;
    localparam logic [2:0] ACT_RSVD7   = 3'd7;
    localparam logic [1:0] FRAME_BAD   = 2'd2;
    localparam logic [1:0] FRAME_SPARE = 2'd3;
    localparam int IN_W        = $bits(bcrc_pkg::in_beat_t);
    localparam int STALL_LIMIT = 2000;

    localparam bcrc_pkg::cfg_t CFG_DEFAULT = '{8'd3, 1'b1, 16'd10, 16'd100, 16'd10, 8'd21};
    localparam bcrc_pkg::out_beat_t QUIET = '0;
    localparam bcrc_pkg::out_beat_t UNSOL =
        '{LINK_IDLE, 1'b0, 1'b0, 1'b0, bcrc_pkg::ST_SUCCESS, 1'b1, 8'd0};
    localparam bcrc_pkg::out_beat_t PEND  =
        '{LINK_WAIT_BUS, 1'b0, 1'b0, 1'b0, bcrc_pkg::ST_SUCCESS, 1'b0, 8'd0};
    localparam bcrc_pkg::out_beat_t BUSY  =
        '{LINK_WAIT_BUS, 1'b1, 1'b0, 1'b0, bcrc_pkg::ST_SUCCESS, 1'b0, 8'd0};

    logic                             aclk      = 1'b0;
    logic                             aresetn   = 1'b0;
    logic                             s_valid   = 1'b0;
    logic                             s_ready;
    bcrc_pkg::in_beat_t               s_data    = '0;
    logic                             m_valid;
    logic                             m_ready   = 1'b0;
    bcrc_pkg::out_beat_t              m_data;
    logic                             cfg_we    = 1'b0;
    logic [bcrc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bcrc_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;

    bit                  beat_typed = 1'b0;
    bcrc_pkg::out_beat_t beat_want  = '0;
    bit                  src_gaps   = 1'b1;
    bit                  snk_gaps   = 1'b1;
    int                  bus_free_pct = 50;

    link_mode_t     lk_mode;
    logic [15:0]    lk_ticks;
    logic [7:0]     lk_tally;
    logic           lk_pending;
    logic           lk_want_reply;
    logic           lk_echo;
    bcrc_pkg::cfg_t lk_cfg;
    logic           st_done;
    logic           st_tx;
    logic [2:0]     st_code;

    bcrc_pkg::out_beat_t outcome_q[$];
    plan_row_t           plan[$];
    bcrc_pkg::out_beat_t mon_want;
    int                  errors = 0;
    int                  n_seen = 0;
    int                  stall_cycles = 0;

    bus_command_retry_controller u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #2 aclk = ~aclk;

    function automatic void go_mode(link_mode_t m);
        lk_mode  = m;
        lk_ticks = '0;
    endfunction

    function automatic void close_cmd(logic [2:0] code);
        if (lk_pending) begin
            st_done    = 1'b1;
            st_code    = code;
            lk_pending = 1'b0;
            go_mode(LINK_IDLE);
        end
    endfunction

    function automatic void fault(logic [2:0] code);
        if (!lk_cfg.retry_en) begin
            close_cmd(code);
        end else if (lk_pending) begin
            if (lk_tally != 8'hFF) lk_tally = lk_tally + 8'd1;
            if (lk_tally >= lk_cfg.retry_limit) close_cmd(bcrc_pkg::ST_TIMEOUT);
            else go_mode(LINK_BACKOFF);
        end
    endfunction

    function automatic bcrc_pkg::out_beat_t link_step(bcrc_pkg::in_beat_t b);
        bcrc_pkg::out_beat_t r;
        logic                dropped;
        r       = '0;
        dropped = 1'b0;
        st_done = 1'b0;
        st_tx   = 1'b0;
        st_code = bcrc_pkg::ST_SUCCESS;
        case (b.action)
            bcrc_pkg::ACT_TICK: begin
                if (lk_ticks != 16'hFFFF) lk_ticks = lk_ticks + 16'd1;
                case (lk_mode)
                    LINK_WAIT_BUS: begin
                        if (b.bus_idle) begin
                            if (lk_pending && b.send_ok) begin
                                st_tx   = 1'b1;
                                lk_echo = 1'b1;
                                if (lk_want_reply) go_mode(LINK_WAIT_REPLY);
                                else close_cmd(bcrc_pkg::ST_SUCCESS);
                            end else begin
                                lk_echo = 1'b0;
                                close_cmd(bcrc_pkg::ST_FAILED);
                            end
                        end else if (lk_ticks >= lk_cfg.idle_wait_limit) begin
                            fault(bcrc_pkg::ST_TIMEOUT);
                        end
                    end
                    LINK_WAIT_REPLY:
                        if (lk_ticks >= lk_cfg.reply_wait_limit) fault(bcrc_pkg::ST_TIMEOUT);
                    LINK_BACKOFF: if (lk_ticks >= lk_cfg.retry_pause) go_mode(LINK_WAIT_BUS);
                    default: ;
                endcase
            end
            bcrc_pkg::ACT_SEND_REPLY, bcrc_pkg::ACT_SEND_ONLY: begin
                if (lk_pending) begin
                    r.send_refused = 1'b1;
                end else begin
                    lk_pending    = 1'b1;
                    lk_want_reply = (b.action == bcrc_pkg::ACT_SEND_REPLY);
                    lk_tally      = '0;
                    go_mode(LINK_WAIT_BUS);
                end
            end
            bcrc_pkg::ACT_FRAME: begin
                if (lk_echo) begin
                    lk_echo = 1'b0;
                    dropped = b.frame_is_echo;
                end
                if (!dropped) begin
                    if (b.frame_class == bcrc_pkg::FRAME_CRC) begin
                        if (lk_mode == LINK_WAIT_REPLY) fault(bcrc_pkg::ST_CRC);
                    end else if (b.frame_class == bcrc_pkg::FRAME_GOOD) begin
                        if (lk_pending && lk_want_reply && lk_mode == LINK_WAIT_REPLY) begin
                            if (b.frame_has_data && b.frame_first_byte == lk_cfg.nak_code)
                                fault(bcrc_pkg::ST_NAK);
                            else
                                close_cmd(bcrc_pkg::ST_SUCCESS);
                        end else begin
                            r.unsolicited = 1'b1;
                        end
                    end
                end
            end
            bcrc_pkg::ACT_CANCEL: close_cmd(bcrc_pkg::ST_FAILED);
            default: ;
        endcase
        r.mode_now     = lk_mode;
        r.transmit_now = st_tx;
        r.command_done = st_done;
        r.done_status  = st_done ? st_code : bcrc_pkg::ST_SUCCESS;
        r.retries_used = lk_tally;
        return r;
    endfunction

    function automatic bcrc_pkg::in_beat_t draw_beat();
        bcrc_pkg::in_beat_t b;
        int                 roll;
        int                 pick;
        b    = IN_W'($urandom);
        roll = $urandom_range(0, 99);
        if (roll < 15) return b;
        case (lk_mode)
            LINK_IDLE: begin
                if (roll < 75) begin
                    b.action = ($urandom_range(0, 2) != 0) ? bcrc_pkg::ACT_SEND_REPLY
                                                           : bcrc_pkg::ACT_SEND_ONLY;
                end else if (roll < 90) begin
                    b.action = bcrc_pkg::ACT_TICK;
                end else begin
                    b.action      = bcrc_pkg::ACT_FRAME;
                    b.frame_class = bcrc_pkg::FRAME_GOOD;
                end
            end
            LINK_WAIT_BUS: begin
                if (roll < 85) begin
                    b.action   = bcrc_pkg::ACT_TICK;
                    b.bus_idle = ($urandom_range(0, 99) < bus_free_pct);
                    b.send_ok  = ($urandom_range(0, 9) != 0);
                end else if (roll < 93) begin
                    b.action = ($urandom_range(0, 1) != 0) ? bcrc_pkg::ACT_SEND_REPLY
                                                           : bcrc_pkg::ACT_SEND_ONLY;
                end else begin
                    b.action = bcrc_pkg::ACT_CANCEL;
                end
            end
            LINK_WAIT_REPLY: begin
                if (lk_echo && roll < 80) begin
                    b.action        = bcrc_pkg::ACT_FRAME;
                    b.frame_class   = bcrc_pkg::FRAME_GOOD;
                    b.frame_is_echo = 1'b1;
                end else if (roll < 45) begin
                    b.action = bcrc_pkg::ACT_TICK;
                end else if (roll < 97) begin
                    b.action = bcrc_pkg::ACT_FRAME;
                    pick     = $urandom_range(0, 9);
                    b.frame_class = (pick < 7) ? bcrc_pkg::FRAME_GOOD :
                                    (pick < 9) ? bcrc_pkg::FRAME_CRC : FRAME_BAD;
                    if ($urandom_range(0, 1) != 0) b.frame_first_byte = lk_cfg.nak_code;
                end else begin
                    b.action = bcrc_pkg::ACT_CANCEL;
                end
            end
            default: b.action = (roll < 92) ? bcrc_pkg::ACT_TICK : bcrc_pkg::ACT_CANCEL;
        endcase
        return b;
    endfunction

    task automatic report(string what, int got, int want);
        errors++;
        $display("mismatch at result %0d: %s got %0h want %0h", n_seen, what, got, want);
    endtask

    task automatic check_beat(bcrc_pkg::out_beat_t got, bcrc_pkg::out_beat_t want);
        if (got.mode_now !== want.mode_now) report("mode_now", got.mode_now, want.mode_now);
        if (got.send_refused !== want.send_refused)
            report("send_refused", got.send_refused, want.send_refused);
        if (got.transmit_now !== want.transmit_now)
            report("transmit_now", got.transmit_now, want.transmit_now);
        if (got.command_done !== want.command_done)
            report("command_done", got.command_done, want.command_done);
        if (got.done_status !== want.done_status)
            report("done_status", got.done_status, want.done_status);
        if (got.unsolicited !== want.unsolicited)
            report("unsolicited", got.unsolicited, want.unsolicited);
        if (got.retries_used !== want.retries_used)
            report("retries_used", got.retries_used, want.retries_used);
    endtask

    // The result side is handled before the input side so that a beat
    // accepted in this cycle is never matched against an older result.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                n_seen++;
                if (outcome_q.size() == 0) begin
                    report("result beat with nothing expected", m_data, 0);
                end else begin
                    mon_want = outcome_q.pop_front();
                    check_beat(m_data, mon_want);
                end
            end
            if (s_valid && s_ready) begin
                mon_want = link_step(s_data);
                outcome_q.push_back(beat_typed ? beat_want : mon_want);
            end
        end
    end

    always @(negedge aclk) begin
        m_ready <= !snk_gaps || ($urandom_range(0, 99) >= 32);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic add_row(bcrc_pkg::in_beat_t beat, bit typed, bcrc_pkg::out_beat_t want);
        plan.push_back('{beat, typed, want});
    endtask

    task automatic wait_slot(bit drain);
        @(negedge aclk);
        while ((drain && outcome_q.size() != 0) || (src_gaps && $urandom_range(0, 99) < 32)) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
    endtask

    task automatic wait_accept();
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(logic [bcrc_pkg::CFG_INDEX_W-1:0] idx,
                             logic [bcrc_pkg::CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    task automatic set_link_cfg(bcrc_pkg::cfg_t c);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
        write_reg(bcrc_pkg::CFG_RETRY_LIMIT, 16'(c.retry_limit));
        write_reg(bcrc_pkg::CFG_RETRY_EN, 16'(c.retry_en));
        write_reg(bcrc_pkg::CFG_IDLE_WAIT, c.idle_wait_limit);
        write_reg(bcrc_pkg::CFG_REPLY_WAIT, c.reply_wait_limit);
        write_reg(bcrc_pkg::CFG_RETRY_PAUSE, c.retry_pause);
        write_reg(bcrc_pkg::CFG_NAK_CODE, 16'(c.nak_code));
        @(negedge aclk);
        cfg_we <= 1'b0;
        lk_cfg = c;
    endtask

    task automatic run_random(bcrc_pkg::cfg_t c, int n, bit gaps, int free_pct, bit hold);
        set_link_cfg(c);
        src_gaps     = gaps;
        snk_gaps     = gaps;
        bus_free_pct = free_pct;
        for (int i = 0; i < n; i++) begin
            wait_slot(hold && i == n / 2);
            s_valid    <= 1'b1;
            s_data     <= draw_beat();
            beat_typed <= 1'b0;
            wait_accept();
        end
    endtask

    initial begin
        lk_mode       = LINK_IDLE;
        lk_ticks      = '0;
        lk_tally      = '0;
        lk_pending    = 1'b0;
        lk_want_reply = 1'b0;
        lk_echo       = 1'b0;
        lk_cfg        = CFG_DEFAULT;

        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_TICK, 1'b1, 1'b1,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b1, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_CANCEL, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b1, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b1, UNSOL);
        add_row(bcrc_pkg::in_beat_t'{ACT_RSVD5, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b1, QUIET);
        add_row(bcrc_pkg::in_beat_t'{ACT_RSVD7, 1'b1, 1'b1,
                FRAME_SPARE, 1'b1, 1'b1, 8'hFF}, 1'b1, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                FRAME_SPARE, 1'b0, 1'b1, 8'hFF}, 1'b1, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                bcrc_pkg::FRAME_CRC, 1'b0, 1'b1, 8'h00}, 1'b1, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_SEND_REPLY, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b1, PEND);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_SEND_ONLY, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b1, BUSY);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_TICK, 1'b0, 1'b1,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_TICK, 1'b1, 1'b1,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b1, 1'b1, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                FRAME_BAD, 1'b0, 1'b1, 8'hFF}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b1, CFG_DEFAULT.nak_code}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_CANCEL, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_SEND_ONLY, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_TICK, 1'b1, 1'b1,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                bcrc_pkg::FRAME_CRC, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_SEND_REPLY, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_TICK, 1'b1, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_SEND_REPLY, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_TICK, 1'b1, 1'b1,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b1, 8'hFF}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_SEND_REPLY, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_TICK, 1'b1, 1'b1,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b1, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_FRAME, 1'b0, 1'b0,
                bcrc_pkg::FRAME_CRC, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);
        add_row(bcrc_pkg::in_beat_t'{bcrc_pkg::ACT_CANCEL, 1'b0, 1'b0,
                bcrc_pkg::FRAME_GOOD, 1'b0, 1'b0, 8'h00}, 1'b0, QUIET);

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (plan[i]) begin
            wait_slot(1'b0);
            s_valid    <= 1'b1;
            s_data     <= plan[i].beat;
            beat_typed <= plan[i].typed;
            beat_want  <= plan[i].want;
            wait_accept();
        end

        run_random(bcrc_pkg::cfg_t'{8'd3, 1'b1, 16'd4, 16'd6, 16'd3, 8'd21},
                   100, 1'b1, 60, 1'b0);
        run_random(bcrc_pkg::cfg_t'{8'd0, 1'b1, 16'd0, 16'd0, 16'd0, 8'd0},
                   100, 1'b1, 50, 1'b0);
        run_random(bcrc_pkg::cfg_t'{8'd255, 1'b1, 16'd0, 16'd1, 16'd0, 8'd255},
                   150, 1'b1, 5, 1'b0);
        run_random(bcrc_pkg::cfg_t'{8'd2, 1'b0, 16'd3, 16'd5, 16'd2, 8'd128},
                   150, 1'b1, 40, 1'b0);
        run_random(bcrc_pkg::cfg_t'{8'd1, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd21},
                   80, 1'b1, 30, 1'b0);
        run_random(CFG_DEFAULT, 120, 1'b0, 60, 1'b1);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
